// ===== rtl/chacha20_poly1305_encrypt_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ChaCha20-Poly1305 encrypt core
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_POLY1305_ENCRYPT_CORE_MACROS_SVH
`define CHACHA20_POLY1305_ENCRYPT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cpe assertion failed");
// next-cycle implication
`define CPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cpe assertion failed");
`else
`define CPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/cpe_pkg.sv =====
// ----------------------------------------------------------------------------
// cpe_pkg
// Constants and helpers shared by the ChaCha20-Poly1305 encrypt core.
// ----------------------------------------------------------------------------
`default_nettype none

package cpe_pkg;

	typedef logic [31:0] word_t;

	// ChaCha20 state constants ("expand 32-byte k")
	localparam word_t SIGMA0 = 32'h61707865;
	localparam word_t SIGMA1 = 32'h3320646e;
	localparam word_t SIGMA2 = 32'h79622d32;
	localparam word_t SIGMA3 = 32'h6b206574;

	// Poly1305 r clamping
	localparam word_t CLAMP_LO = 32'h0fffffff;
	localparam word_t CLAMP_HI = 32'h0ffffffc;

	// associated data length in bytes
	localparam word_t AAD_BYTES = 32'd12;

	// stream widths
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_AAD_LO    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_AAD_HI    = 3'd7;

	// result kinds
	localparam logic KIND_CT  = 1'b0;
	localparam logic KIND_TAG = 1'b1;

	localparam logic [2:0] FULL_WORD = 3'd4;

	// byte order reversal
	function automatic word_t swap32(input word_t v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/chacha20_poly1305_encrypt_core.sv =====
// A word that starts a keystream block waits for that block to be computed; the first
// word of a message also waits for key block 0 and the AAD absorb. Every fourth word
// adds a Poly1305 absorb (one 32x32 limb product per cycle); the tag adds up to two
// absorbs. The core takes no new word until it is done with the last one.
// arst_n clears control state, config registers and the output register.
// ----------------------------------------------------------------------------
// chacha20_poly1305_encrypt_core
// ChaCha20 encryption with Poly1305 tag over AAD and ciphertext.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chacha20_poly1305_encrypt_core_macros.svh"

module chacha20_poly1305_encrypt_core #(
	parameter int MAX_MESSAGE_BYTES = 16384
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration writes
	input  wire logic                            cfg_we,
	input  wire logic [cpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cpe_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [cpe_pkg::S_TDATA_W-1:0]   s_tdata,   // msg_word[31:0], byte_count[34:32]
	input  wire logic                            s_tlast,   // last
	// output stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [cpe_pkg::M_TDATA_W-1:0]        m_tdata,   // out_word[31:0], out_bytes[34:32]
	output logic                                 m_tuser,   // kind
	output logic                                 m_tlast    // end_of_run
);
	import cpe_pkg::*;

	localparam int MBW = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [MBW:0] MAX_MB = (MBW+1)'(MAX_MESSAGE_BYTES);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_KEYS, ST_WORD, ST_EMIT, ST_LAST_CHK, ST_LEN,
		ST_FIN, ST_TAG, ST_BLK_INIT, ST_BLK_RND, ST_BLK_ADD,
		ST_ABS_ADD, ST_ABS_MUL, ST_ABS_DRAIN, ST_ABS_RED
	} state_t;

	typedef enum logic [1:0] {SRC_AAD, SRC_PEND, SRC_LEN} msg_src_t;

	// control
	state_t       state_q, ret_q;
	msg_src_t     src_q;
	logic [6:0]   cnt_q;
	logic [1:0]   mj_q;
	logic [2:0]   mk_q;
	logic         pv_q;
	logic         keys_ready_q;
	logic [3:0]   wi_q;
	word_t        blk_ctr_q, cur_ctr_q;
	logic [MBW-1:0] mb_q;
	word_t        acc_q [5];
	logic         m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// configuration
	logic [63:0]  key_q [4];
	logic [63:0]  nonce_lo_q, aad_lo_q;
	word_t        nonce_hi_q, aad_hi_q;

	// datapath
	word_t        x_q [16];
	word_t        r_q [4], f_q [4], s_q [4], pend_q [4];
	logic [63:0]  d_q [4];
	logic [63:0]  p_q;
	logic [1:0]   pj_q;
	logic [35:0]  tc_q;
	logic [32:0]  d4_q;
	word_t        w_q;
	logic [2:0]   n_q;
	logic         last_q;

	// combinational
	word_t        st [16];
	word_t        rnd_x [16], perm_x [16];
	word_t        lane_p [4], lane_q [4], lane_r [4], lane_np [4], lane_xr [4], lane_nr [4];
	word_t        abs_m [5];
	logic [2:0]   limb_idx, acc_ridx;
	word_t        acc_rd;
	logic [35:0]  limb_sum;
	logic [1:0]   coef_idx;
	word_t        coef;
	logic [MBW:0] mb_plus;
	logic         word_ok, out_free, out_load;
	word_t        ks, ct_mask, ct_c;
	logic [2:0]   s_n;
	word_t        a4m;
	logic [30:0]  fix_q_in;
	logic [30:0]  red_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free && (state_q == ST_EMIT || state_q == ST_TAG);

	// input byte count: short only on the last word, capped at four
	assign s_n = !s_tlast ? FULL_WORD :
		((s_tdata[34:32] > FULL_WORD) ? FULL_WORD : s_tdata[34:32]);

	// ChaCha input state
	always_comb begin
		st[0]  = SIGMA0;            st[1]  = SIGMA1;
		st[2]  = SIGMA2;            st[3]  = SIGMA3;
		st[4]  = key_q[0][31:0];    st[5]  = key_q[0][63:32];
		st[6]  = key_q[1][31:0];    st[7]  = key_q[1][63:32];
		st[8]  = key_q[2][31:0];    st[9]  = key_q[2][63:32];
		st[10] = key_q[3][31:0];    st[11] = key_q[3][63:32];
		st[12] = cur_ctr_q;
		st[13] = nonce_lo_q[31:0];  st[14] = nonce_lo_q[63:32];
		st[15] = nonce_hi_q;
	end

	// round step: four column lanes; rows re-rotated after each half round
	always_comb begin
		rnd_x = x_q;
		for (int i = 0; i < 4; i++) begin
			lane_p[i]  = cnt_q[0] ? x_q[8+i]  : x_q[i];
			lane_q[i]  = cnt_q[0] ? x_q[12+i] : x_q[4+i];
			lane_r[i]  = cnt_q[0] ? x_q[4+i]  : x_q[12+i];
			lane_np[i] = lane_p[i] + lane_q[i];
			lane_xr[i] = lane_r[i] ^ lane_np[i];
			unique case (cnt_q[1:0])
				2'd0: lane_nr[i] = {lane_xr[i][15:0], lane_xr[i][31:16]};
				2'd1: lane_nr[i] = {lane_xr[i][19:0], lane_xr[i][31:20]};
				2'd2: lane_nr[i] = {lane_xr[i][23:0], lane_xr[i][31:24]};
				2'd3: lane_nr[i] = {lane_xr[i][24:0], lane_xr[i][31:25]};
			endcase
			if (cnt_q[0]) begin
				rnd_x[8+i] = lane_np[i];
				rnd_x[4+i] = lane_nr[i];
			end else begin
				rnd_x[i]    = lane_np[i];
				rnd_x[12+i] = lane_nr[i];
			end
		end
		perm_x = rnd_x;
		if (cnt_q[1:0] == 2'd3) begin
			for (int i = 0; i < 4; i++) begin
				if (!cnt_q[2]) begin
					// to diagonal layout
					perm_x[4+i]  = rnd_x[4+((i+1)&3)];
					perm_x[8+i]  = rnd_x[8+((i+2)&3)];
					perm_x[12+i] = rnd_x[12+((i+3)&3)];
				end else begin
					// back to column layout
					perm_x[4+i]  = rnd_x[4+((i+3)&3)];
					perm_x[8+i]  = rnd_x[8+((i+2)&3)];
					perm_x[12+i] = rnd_x[12+((i+1)&3)];
				end
			end
		end
	end

	// Poly1305 message block source
	always_comb begin
		abs_m[4] = 32'd1;
		unique case (src_q)
			SRC_AAD: begin
				abs_m[0] = aad_lo_q[31:0];
				abs_m[1] = aad_lo_q[63:32];
				abs_m[2] = aad_hi_q;
				abs_m[3] = '0;
			end
			SRC_PEND: begin
				abs_m[0] = pend_q[0];
				abs_m[1] = pend_q[1];
				abs_m[2] = pend_q[2];
				abs_m[3] = pend_q[3];
			end
			SRC_LEN: begin
				abs_m[0] = AAD_BYTES;
				abs_m[1] = '0;
				abs_m[2] = 32'(mb_q);
				abs_m[3] = '0;
			end
			default: begin
				abs_m[0] = '0;
				abs_m[1] = '0;
				abs_m[2] = '0;
				abs_m[3] = '0;
			end
		endcase
	end

	// limb index for the carry chains
	always_comb begin
		limb_idx = cnt_q[2:0];
		if (state_q == ST_ABS_RED)
			limb_idx = (cnt_q[2:0] == 3'd0) ? 3'd4 : 3'(cnt_q[2:0] - 3'd1);
	end

	assign acc_ridx = (state_q == ST_ABS_MUL) ? mk_q : limb_idx;
	assign acc_rd   = acc_q[acc_ridx];

	// multiplier operand: r for the lower diagonal, 5*(r>>2) above it
	assign coef_idx = 2'(mj_q - mk_q[1:0]);
	assign coef     = (mk_q <= {1'b0, mj_q}) ? r_q[coef_idx] : f_q[coef_idx];

	// a4 * (r0 & 3), low 32 bits
	assign a4m   = (r_q[0][0] ? acc_rd : '0) + (r_q[0][1] ? {acc_rd[30:0], 1'b0} : '0);
	assign red_q = d4_q[32:2];

	// one limb of the add, reduce, final and tag carry chains
	always_comb begin
		limb_sum = '0;
		fix_q_in = '0;
		unique case (state_q)
			ST_ABS_ADD: limb_sum = ((cnt_q[2:0] == 3'd0) ? 36'd0 : 36'(tc_q[35:32]))
				+ 36'(acc_rd) + 36'(abs_m[limb_idx]);
			ST_ABS_RED: begin
				unique case (cnt_q[2:0])
					3'd1: limb_sum = 36'({red_q, 2'b00}) + 36'(red_q) + 36'(d_q[0][31:0]);
					3'd2: limb_sum = 36'(tc_q[35:32]) + 36'(d_q[1][31:0])
						+ 36'(d_q[0][63:32]);
					3'd3: limb_sum = 36'(tc_q[35:32]) + 36'(d_q[2][31:0])
						+ 36'(d_q[1][63:32]);
					3'd4: limb_sum = 36'(tc_q[35:32]) + 36'(d_q[3][31:0])
						+ 36'(d_q[2][63:32]);
					3'd5: limb_sum = 36'(tc_q[35:32]) + 36'(d4_q[1:0]);
					default: limb_sum = '0;
				endcase
			end
			ST_FIN: begin
				limb_sum = ((cnt_q[2:0] == 3'd0) ? 36'd5 : 36'(tc_q[35:32])) + 36'(acc_rd);
				fix_q_in = limb_sum[32:2];
			end
			ST_TAG: limb_sum = ((cnt_q[2:0] == 3'd0) ? tc_q : 36'(tc_q[35:32]))
				+ 36'(acc_rd) + 36'(s_q[cnt_q[1:0]]);
			default: limb_sum = '0;
		endcase
	end

	// ciphertext word
	assign ks      = x_q[wi_q];
	assign ct_mask = (n_q == 3'd1) ? 32'h000000ff :
		(n_q == 3'd2) ? 32'h0000ffff :
		(n_q == 3'd3) ? 32'h00ffffff : 32'hffffffff;
	assign ct_c    = (swap32(w_q) ^ ks) & ct_mask;
	assign mb_plus = {1'b0, mb_q} + (MBW+1)'(n_q);
	assign word_ok = (n_q != 3'd0) && (mb_plus <= MAX_MB);

	// sequencer, control state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ret_q        <= ST_IDLE;
			src_q        <= SRC_AAD;
			cnt_q        <= '0;
			mj_q         <= '0;
			mk_q         <= '0;
			pv_q         <= 1'b0;
			keys_ready_q <= 1'b0;
			wi_q         <= '0;
			blk_ctr_q    <= 32'd1;
			cur_ctr_q    <= '0;
			mb_q         <= '0;
			for (int k = 0; k < 5; k++) acc_q[k] <= '0;
			for (int k = 0; k < 4; k++) key_q[k] <= '0;
			nonce_lo_q   <= '0;
			nonce_hi_q   <= '0;
			aad_lo_q     <= '0;
			aad_hi_q     <= '0;
			m_tvalid_q   <= 1'b0;
			m_tuser_q    <= KIND_CT;
			m_tlast_q    <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY_0_7:   key_q[0]   <= cfg_data;
					REG_KEY_8_15:  key_q[1]   <= cfg_data;
					REG_KEY_16_23: key_q[2]   <= cfg_data;
					REG_KEY_24_31: key_q[3]   <= cfg_data;
					REG_NONCE_LO:  nonce_lo_q <= cfg_data;
					REG_NONCE_HI:  nonce_hi_q <= cfg_data[31:0];
					REG_AAD_LO:    aad_lo_q   <= cfg_data;
					REG_AAD_HI:    aad_hi_q   <= cfg_data[31:0];
				endcase
			end

			// output valid: load wins over the transfer of the old word
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;

			pv_q <= (state_q == ST_ABS_MUL);

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!keys_ready_q) begin
						cur_ctr_q <= '0;
						ret_q     <= ST_KEYS;
						state_q   <= ST_BLK_INIT;
					end else begin
						state_q <= ST_WORD;
					end
				end
				// block 0 gives r and s; then absorb the AAD
				ST_KEYS: begin
					for (int k = 0; k < 5; k++) acc_q[k] <= '0;
					blk_ctr_q    <= 32'd1;
					wi_q         <= '0;
					mb_q         <= '0;
					keys_ready_q <= 1'b1;
					src_q        <= SRC_AAD;
					ret_q        <= ST_WORD;
					cnt_q        <= '0;
					state_q      <= ST_ABS_ADD;
				end
				ST_WORD: begin
					if (word_ok) begin
						if (wi_q == 4'd0) begin
							cur_ctr_q <= blk_ctr_q;
							blk_ctr_q <= blk_ctr_q + 32'd1;
							ret_q     <= ST_EMIT;
							state_q   <= ST_BLK_INIT;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						state_q <= ST_LAST_CHK;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tuser_q  <= KIND_CT;
						m_tlast_q  <= 1'b0;
						m_tdata_q  <= {5'd0, n_q, swap32(ct_c)};
						wi_q       <= wi_q + 4'd1;
						mb_q       <= mb_plus[MBW-1:0];
						if (wi_q[1:0] == 2'd3) begin
							src_q   <= SRC_PEND;
							ret_q   <= ST_LAST_CHK;
							cnt_q   <= '0;
							state_q <= ST_ABS_ADD;
						end else begin
							state_q <= ST_LAST_CHK;
						end
					end
				end
				ST_LAST_CHK: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (wi_q[1:0] != 2'd0) begin
						src_q   <= SRC_PEND;
						ret_q   <= ST_LEN;
						cnt_q   <= '0;
						state_q <= ST_ABS_ADD;
					end else begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					src_q   <= SRC_LEN;
					ret_q   <= ST_FIN;
					cnt_q   <= '0;
					state_q <= ST_ABS_ADD;
				end
				ST_FIN: begin
					if (cnt_q[2:0] == 3'd4) begin
						cnt_q   <= '0;
						state_q <= ST_TAG;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_TAG: begin
					if (out_free) begin
						m_tuser_q  <= KIND_TAG;
						m_tlast_q  <= (cnt_q[1:0] == 2'd3);
						m_tdata_q  <= {5'd0, FULL_WORD, limb_sum[31:0]};
						if (cnt_q[1:0] == 2'd3) begin
							keys_ready_q <= 1'b0;
							wi_q         <= '0;
							blk_ctr_q    <= 32'd1;
							mb_q         <= '0;
							for (int k = 0; k < 5; k++) acc_q[k] <= '0;
							cnt_q        <= '0;
							state_q      <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 7'd1;
						end
					end
				end
				ST_BLK_INIT: begin
					cnt_q   <= '0;
					state_q <= ST_BLK_RND;
				end
				ST_BLK_RND: begin
					if (cnt_q == 7'd79) begin
						cnt_q   <= '0;
						state_q <= ST_BLK_ADD;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_BLK_ADD: state_q <= ret_q;
				ST_ABS_ADD: begin
					acc_q[limb_idx] <= limb_sum[31:0];
					if (cnt_q[2:0] == 3'd4) begin
						cnt_q   <= '0;
						mj_q    <= '0;
						mk_q    <= '0;
						state_q <= ST_ABS_MUL;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_ABS_MUL: begin
					if (mk_q == 3'd4 && mj_q == 2'd3) begin
						state_q <= ST_ABS_DRAIN;
					end else if (mk_q == 3'd4) begin
						mk_q <= '0;
						mj_q <= mj_q + 2'd1;
					end else begin
						mk_q <= mk_q + 3'd1;
					end
				end
				ST_ABS_DRAIN: begin
					cnt_q   <= '0;
					state_q <= ST_ABS_RED;
				end
				ST_ABS_RED: begin
					if (cnt_q[2:0] != 3'd0)
						acc_q[limb_idx] <= limb_sum[31:0];
					if (cnt_q[2:0] == 3'd5) begin
						cnt_q   <= '0;
						state_q <= ret_q;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// input capture
		if (state_q == ST_IDLE && s_tvalid) begin
			w_q    <= s_tdata[31:0];
			n_q    <= s_n;
			last_q <= s_tlast;
		end

		// ChaCha working state, reused as keystream
		if (state_q == ST_BLK_INIT)
			x_q <= st;
		else if (state_q == ST_BLK_RND)
			x_q <= perm_x;
		else if (state_q == ST_BLK_ADD)
			for (int k = 0; k < 16; k++) x_q[k] <= x_q[k] + st[k];

		// one-time key from block 0
		if (state_q == ST_KEYS) begin
			for (int k = 0; k < 4; k++) begin
				r_q[k] <= x_q[k] & ((k == 0) ? CLAMP_LO : CLAMP_HI);
				f_q[k] <= (x_q[k] & ((k == 0) ? CLAMP_LO : CLAMP_HI) & 32'hfffffffc)
					+ {2'b00, x_q[k][31:2] & ((k == 0) ? CLAMP_LO[31:2] : CLAMP_HI[31:2])};
				s_q[k] <= x_q[4+k];
			end
		end

		// ciphertext block for Poly1305, zero-padded at the end
		if (state_q == ST_EMIT && out_free)
			pend_q[wi_q[1:0]] <= ct_c;
		if (state_q == ST_LAST_CHK && last_q && wi_q[1:0] != 2'd0)
			for (int k = 0; k < 4; k++)
				if (2'(k) >= wi_q[1:0]) pend_q[k] <= '0;

		// limb product, registered before accumulation
		if (state_q == ST_ABS_MUL) begin
			p_q  <= 64'(acc_rd) * 64'(coef);
			pj_q <= mj_q;
		end

		if (state_q == ST_ABS_ADD && cnt_q[2:0] == 3'd4)
			for (int k = 0; k < 4; k++) d_q[k] <= '0;
		else if (pv_q)
			d_q[pj_q] <= d_q[pj_q] + p_q;

		// top limb of the product
		if (state_q == ST_ABS_RED && cnt_q[2:0] == 3'd0)
			d4_q <= 33'(a4m) + 33'(d_q[3][63:32]);

		// carry register
		if (state_q == ST_ABS_ADD
			|| (state_q == ST_ABS_RED && cnt_q[2:0] != 3'd0)
			|| (state_q == ST_TAG && out_free))
			tc_q <= limb_sum;
		else if (state_q == ST_FIN)
			tc_q <= (cnt_q[2:0] == 3'd4)
				? 36'({fix_q_in, 2'b00}) + 36'(fix_q_in) : limb_sum;
	end

	// checks
	`CPE_ASSERT_IMP(a_mb_bound, clk, arst_n, 1'b1, ({1'b0, mb_q} <= MAX_MB))
	`CPE_ASSERT_IMP(a_idle_clean, clk, arst_n, (state_q == ST_IDLE && !keys_ready_q), (wi_q == 4'd0 && mb_q == '0 && blk_ctr_q == 32'd1))
	`CPE_ASSERT_IMP(a_tag_end, clk, arst_n, (m_tvalid && m_tlast), (m_tuser == KIND_TAG))
	`CPE_ASSERT_NXT(a_keys_load, clk, arst_n, (state_q == ST_KEYS), (keys_ready_q && state_q == ST_ABS_ADD))
	`CPE_ASSERT_IMP(a_mul_done, clk, arst_n, (state_q == ST_ABS_DRAIN), (mj_q == 2'd3 && mk_q == 3'd4 && pv_q))

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// ChaCha20-Poly1305 encrypt core testbench
// Streams messages into the core and checks every ciphertext and tag word.
// A built-in predictor runs ChaCha20 and Poly1305 against the same key,
// nonce and AAD settings. Stimulus covers directed edge cases, random
// messages, several key settings and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cpe_pkg::*;

	localparam int MAX_MSG_BYTES = 16384;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		word_t       data;
		logic [2:0]  nbytes;
		logic        last;
	} msg_item_t;

	typedef struct {
		logic        kind;
		word_t       data;
		logic [2:0]  nbytes;
		logic        eor;
	} cipher_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	chacha20_poly1305_encrypt_core #(.MAX_MESSAGE_BYTES(MAX_MSG_BYTES)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus and expectation stores
	msg_item_t   plaintext_q[$];
	cipher_out_t expected_cipher_q[$];

	int tx_idle_pct = 29;
	int rx_idle_pct = 55;
	bit stall_request = 1'b0;
	bit stall_done = 1'b0;
	int stall_left = 0;
	logic in_xfer = 1'b0;

	int cycles = 0;
	int errors = 0;
	int words_sent = 0;
	int ct_words = 0;
	int tag_words = 0;
	int messages = 0;

	// predictor copy of the registers and the core state
	logic [63:0] key_lo_r = '0, key_mid_r = '0, key_hi_r = '0, key_top_r = '0;
	logic [63:0] nonce_lo_r = '0, aad_lo_r = '0;
	word_t nonce_hi_r = '0, aad_hi_r = '0;
	word_t ks[16];
	word_t blk_ctr = 32'd1;
	logic [3:0] widx = '0;
	word_t acc[5] = '{default: '0};
	word_t pr[4];
	word_t ps[4];
	word_t pend[4];
	int msg_bytes = 0;
	bit keys_ready = 1'b0;

	function automatic word_t rotl(input word_t v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void quarter_round(inout word_t x[16], input int a, b, c, d);
		x[a] += x[b]; x[d] = rotl(x[d] ^ x[a], 16);
		x[c] += x[d]; x[b] = rotl(x[b] ^ x[c], 12);
		x[a] += x[b]; x[d] = rotl(x[d] ^ x[a], 8);
		x[c] += x[d]; x[b] = rotl(x[b] ^ x[c], 7);
	endfunction

	function automatic void chacha_keystream_block(input word_t ctr, output word_t dst[16]);
		word_t st[16];
		word_t x[16];
		st[0] = SIGMA0; st[1] = SIGMA1; st[2] = SIGMA2; st[3] = SIGMA3;
		st[4] = key_lo_r[31:0];  st[5] = key_lo_r[63:32];
		st[6] = key_mid_r[31:0]; st[7] = key_mid_r[63:32];
		st[8] = key_hi_r[31:0];  st[9] = key_hi_r[63:32];
		st[10] = key_top_r[31:0]; st[11] = key_top_r[63:32];
		st[12] = ctr;
		st[13] = nonce_lo_r[31:0]; st[14] = nonce_lo_r[63:32];
		st[15] = nonce_hi_r;
		x = st;
		for (int i = 0; i < 10; i++) begin
			quarter_round(x, 0, 4, 8, 12); quarter_round(x, 1, 5, 9, 13);
			quarter_round(x, 2, 6, 10, 14); quarter_round(x, 3, 7, 11, 15);
			quarter_round(x, 0, 5, 10, 15); quarter_round(x, 1, 6, 11, 12);
			quarter_round(x, 2, 7, 8, 13); quarter_round(x, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++)
			dst[i] = x[i] + st[i];
	endfunction

	// acc = (acc + m + 2^128) * r, partially reduced mod 2^130 - 5
	function automatic void poly_mac_absorb(input word_t m[4]);
		logic [63:0] t, a0, a1, a2, a3, a4, d0, d1, d2, d3, d4;
		logic [63:0] r0, r1, r2, r3, f0, f1, f2, f3;
		r0 = pr[0]; r1 = pr[1]; r2 = pr[2]; r3 = pr[3];
		f0 = 5 * (r0 >> 2); f1 = 5 * (r1 >> 2); f2 = 5 * (r2 >> 2); f3 = 5 * (r3 >> 2);
		t = 64'(acc[0]) + m[0];            a0 = t[31:0];
		t = (t >> 32) + acc[1] + m[1];     a1 = t[31:0];
		t = (t >> 32) + acc[2] + m[2];     a2 = t[31:0];
		t = (t >> 32) + acc[3] + m[3];     a3 = t[31:0];
		t = (t >> 32) + acc[4] + 64'd1;    a4 = t[31:0];
		d0 = a0 * r0 + a1 * f3 + a2 * f2 + a3 * f1 + a4 * f0;
		d1 = a0 * r1 + a1 * r0 + a2 * f3 + a3 * f2 + a4 * f1;
		d2 = a0 * r2 + a1 * r1 + a2 * r0 + a3 * f3 + a4 * f2;
		d3 = a0 * r3 + a1 * r2 + a2 * r1 + a3 * r0 + a4 * f3;
		d4 = ((a4 * (r0 & 64'd3)) & 64'hffffffff) + (d3 >> 32);
		t = 5 * (d4 >> 2) + d0[31:0];            acc[0] = t[31:0]; t >>= 32;
		t += 64'(d1[31:0]) + (d0 >> 32);          acc[1] = t[31:0]; t >>= 32;
		t += 64'(d2[31:0]) + (d1 >> 32);          acc[2] = t[31:0]; t >>= 32;
		t += 64'(d3[31:0]) + (d2 >> 32);          acc[3] = t[31:0]; t >>= 32;
		t += d4 & 64'd3;                          acc[4] = t[31:0];
	endfunction

	// one-time key setup at the first word of a message, AAD absorbed first
	function automatic void open_message();
		word_t b0[16];
		word_t m[4];
		chacha_keystream_block('0, b0);
		pr[0] = b0[0] & CLAMP_LO;
		pr[1] = b0[1] & CLAMP_HI;
		pr[2] = b0[2] & CLAMP_HI;
		pr[3] = b0[3] & CLAMP_HI;
		for (int i = 0; i < 4; i++) ps[i] = b0[4 + i];
		acc = '{default: '0};
		m[0] = aad_lo_r[31:0]; m[1] = aad_lo_r[63:32]; m[2] = aad_hi_r; m[3] = '0;
		poly_mac_absorb(m);
		blk_ctr = 32'd1;
		widx = '0;
		msg_bytes = 0;
		keys_ready = 1'b1;
	endfunction

	// expected ciphertext word and, on the last word, the four tag words
	function automatic void encrypt_word(input msg_item_t it);
		int n;
		word_t mask, c, le;
		word_t m[4];
		logic [63:0] t, fix;
		cipher_out_t o;
		n = it.last ? ((it.nbytes > 4) ? 4 : int'(it.nbytes)) : 4;
		if (!keys_ready) open_message();
		if (n > 0 && msg_bytes + n <= MAX_MSG_BYTES) begin
			mask = (n == 4) ? 32'hffffffff : ((32'd1 << (8 * n)) - 1);
			if (widx == 0) begin
				chacha_keystream_block(blk_ctr, ks);
				blk_ctr++;
			end
			le = {<<8{it.data}};
			c = (le ^ ks[widx]) & mask;
			pend[widx[1:0]] = c;
			if (widx[1:0] == 2'd3) poly_mac_absorb(pend);
			widx++;
			msg_bytes += n;
			o.kind = KIND_CT; o.data = {<<8{c}}; o.nbytes = 3'(n); o.eor = 1'b0;
			expected_cipher_q.push_back(o);
		end
		if (it.last) begin
			// zero pad the tail block, then the lengths block
			if (widx[1:0] != 0) begin
				for (int k = widx[1:0]; k < 4; k++) pend[k] = '0;
				poly_mac_absorb(pend);
			end
			m[0] = AAD_BYTES; m[1] = '0; m[2] = word_t'(msg_bytes); m[3] = '0;
			poly_mac_absorb(m);
			t = 64'd5;
			for (int k = 0; k < 4; k++) begin
				t += acc[k]; t >>= 32;
			end
			t += acc[4];
			fix = 5 * (t >> 2);
			t = fix;
			for (int k = 0; k < 4; k++) begin
				t += 64'(acc[k]) + ps[k];
				o.kind = KIND_TAG; o.data = t[31:0]; o.nbytes = FULL_WORD;
				o.eor = (k == 3);
				expected_cipher_q.push_back(o);
				t >>= 32;
			end
			keys_ready = 1'b0;
			widx = '0;
			blk_ctr = 32'd1;
			msg_bytes = 0;
			acc = '{default: '0};
		end
	endfunction

	// predict on input transfers, check output transfers, watchdog
	always @(posedge clk) begin
		cipher_out_t exp_o;
		msg_item_t it;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("chacha20_poly1305_encrypt_core regression: fail");
			$finish;
		end
		in_xfer <= s_tvalid && s_tready;
		if (cfg_we) begin
			case (cfg_index)
				REG_KEY_0_7:   key_lo_r = cfg_data;
				REG_KEY_8_15:  key_mid_r = cfg_data;
				REG_KEY_16_23: key_hi_r = cfg_data;
				REG_KEY_24_31: key_top_r = cfg_data;
				REG_NONCE_LO:  nonce_lo_r = cfg_data;
				REG_NONCE_HI:  nonce_hi_r = cfg_data[31:0];
				REG_AAD_LO:    aad_lo_r = cfg_data;
				REG_AAD_HI:    aad_hi_r = cfg_data[31:0];
				default: ;
			endcase
		end
		if (arst_n && s_tvalid && s_tready) begin
			it.data = s_tdata[31:0];
			it.nbytes = s_tdata[34:32];
			it.last = s_tlast;
			encrypt_word(it);
			words_sent++;
			if (s_tlast) messages++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (m_tuser == KIND_TAG) tag_words++; else ct_words++;
			if (expected_cipher_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transfer: kind %0b data %h bytes %0d last %0b",
						m_tuser, m_tdata[31:0], m_tdata[34:32], m_tlast);
			end else begin
				exp_o = expected_cipher_q.pop_front();
				if (m_tuser !== exp_o.kind || m_tdata[31:0] !== exp_o.data ||
						m_tdata[34:32] !== exp_o.nbytes || m_tlast !== exp_o.eor) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp kind %0b data %h bytes %0d last %0b, got %0b %h %0d %0b",
							exp_o.kind, exp_o.data, exp_o.nbytes, exp_o.eor,
							m_tuser, m_tdata[31:0], m_tdata[34:32], m_tlast);
				end
			end
		end
	end

	// input driver
	always @(negedge clk) begin
		msg_item_t it;
		if (!s_tvalid || in_xfer) begin
			if (arst_n && plaintext_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				it = plaintext_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {5'b0, it.nbytes, it.data};
				s_tlast <= it.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output ready, with one long hold-off on request
	always @(negedge clk) begin
		if (stall_request && !stall_done) begin
			stall_left = 600;
			stall_done = 1'b1;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic wait_idle();
		while (plaintext_q.size() != 0 || s_tvalid || expected_cipher_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all eight registers: 0 all zero, 1 all ones, else random
	task automatic program_regs(input int mode);
		logic [63:0] v[8];
		for (int i = 0; i < 8; i++)
			v[i] = (mode == 0) ? 64'd0 : (mode == 1) ? '1 : {$urandom, $urandom};
		for (int i = 0; i < 8; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= v[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one message; last_bc < 0 picks a random final byte count
	task automatic queue_message(input int nwords, input int last_bc);
		msg_item_t it;
		for (int i = 0; i < nwords; i++) begin
			it.data = $urandom;
			it.last = (i == nwords - 1);
			if (it.last)
				it.nbytes = (last_bc >= 0) ? 3'(last_bc) :
					($urandom_range(9) < 7) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7));
			else
				it.nbytes = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : FULL_WORD;
			plaintext_q.push_back(it);
		end
		while (plaintext_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		msg_item_t it;
		int len;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed: zero key, all-ones key, field extremes
		program_regs(0);
		queue_message(1, 0);                       // empty message
		queue_message(1, 1);
		it.data = 32'h0; it.nbytes = 3'd2; it.last = 1'b0;
		plaintext_q.push_back(it);                 // short word, not last
		it.data = 32'hffffffff; it.nbytes = 3'd0;
		plaintext_q.push_back(it);
		it.data = 32'h0; it.nbytes = 3'd7;
		plaintext_q.push_back(it);
		it.data = 32'hffffffff; it.nbytes = 3'd7; it.last = 1'b1;
		plaintext_q.push_back(it);                 // byte count above four
		while (plaintext_q.size() != 0) @(posedge clk);
		wait_idle();
		program_regs(1);
		queue_message(5, 3);
		queue_message(4, 4);
		queue_message(3, 5);
		queue_message(2, 0);

		// random messages across three idling phases, new keys now and then
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 55 : 0;
			rx_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 29 : 0;
			for (int m = 0; m < 16; m++) begin
				if (m % 4 == 0) begin
					wait_idle();
					program_regs(2);
				end
				if (phase == 0 && m == 3) begin
					// long output hold while a long message keeps coming
					stall_request = 1'b1;
					queue_message(40, -1);
				end else begin
					len = ($urandom_range(5) == 0) ? $urandom_range(24, 16) : $urandom_range(12, 1);
					queue_message(len, -1);
				end
			end
		end

		// closing short message under fresh keys
		wait_idle();
		program_regs(2);
		queue_message(3, -1);

		wait_idle();
		$display("covered %0d messages, %0d input words, %0d ciphertext and %0d tag words",
			messages, words_sent, ct_words, tag_words);
		$display("settings: zero, all-ones and random keys; one long output stall; %0d errors",
			errors);
		if (errors == 0 && expected_cipher_q.size() == 0) begin
			$display("chacha20_poly1305_encrypt_core regression: pass");
		end else begin
			$display("chacha20_poly1305_encrypt_core regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
